### design/salru_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salru_pkg
// Shared types and constants for the set-associative LRU lookup core.
// ----------------------------------------------------------------------------
package salru_pkg;

    localparam int WAYS        = 4;
    localparam int SETS        = 64;

    localparam int ADDR_W      = 32;
    localparam int WADDR_W     = 30;
    localparam int TAG_W       = 30;
    localparam int WORD_W      = 8;
    localparam int OFFSET_W    = 4;
    localparam int MAX_OFFSET  = 8;
    localparam int SET_W       = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W       = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int AGE_W       = WAY_W;
    localparam int POS_W       = $clog2(WADDR_W + 1);
    localparam int SET_OUT_W   = 6;
    localparam int WAY_OUT_W   = 2;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    // register index, taken from paddr[2]
    localparam logic REG_MASK   = 1'b0;
    localparam logic REG_OFFSET = 1'b1;

    localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(2);

    typedef logic [TAG_W-1:0]  tag_t;
    typedef logic [AGE_W-1:0]  age_t;
    typedef logic [WAY_W-1:0]  way_t;
    typedef logic [SET_W-1:0]  set_t;
    typedef logic [WAYS-1:0]   valid_row_t;

    typedef struct packed {
        tag_t [WAYS-1:0] tags;
        age_t [WAYS-1:0] ages;
    } row_t;

    typedef struct packed {
        logic       hit;
        way_t       way;
        logic       ev_valid;
        tag_t       ev_tag;
        row_t       row;
        valid_row_t valid;
    } upd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SPLIT,
        ST_READ,
        ST_UPDATE
    } state_t;

endpackage

### design/set_assoc_cache_lru_lookup_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_lookup_core
// Set-associative cache lookup with per-way LRU age counters and install
// on miss; APB register port for interleave mask and block size.
// ----------------------------------------------------------------------------
// steps: split, row read, then update and write-back once the result
// register is free; no new address is taken until that is done, as the
// read-modify-write of the set row in the tag ram must finish first
// reset: all ways invalid, mask 0, offset_bits 2; no clearing pass needed
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_lookup_core
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [salru_pkg::PADDR_W-1:0]     paddr,
    input  logic [salru_pkg::PDATA_W-1:0]     pwdata,
    output logic [salru_pkg::PDATA_W-1:0]     prdata,
    output logic                              pready,

    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [salru_pkg::ADDR_W-1:0]      address,

    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              hit,
    output logic [salru_pkg::WAY_OUT_W-1:0]   way_number,
    output logic [salru_pkg::SET_OUT_W-1:0]   set_number,
    output logic [salru_pkg::WORD_W-1:0]      word_in_block,
    output logic [salru_pkg::TAG_W-1:0]       tag_out,
    output logic                              evicted_valid,
    output logic [salru_pkg::TAG_W-1:0]       evicted_tag
);

    salru_pkg::state_t state_reg;
    salru_pkg::state_t state_next;

    logic [salru_pkg::WADDR_W-1:0]  mask_reg;
    logic [salru_pkg::OFFSET_W-1:0] offset_reg;
    logic                           cfg_wr;

    logic [salru_pkg::ADDR_W-1:0]   addr_reg;
    logic [salru_pkg::WORD_W-1:0]   word_reg;
    salru_pkg::set_t                set_reg;
    salru_pkg::tag_t                tag_reg;

    logic [salru_pkg::WORD_W-1:0]   split_word;
    salru_pkg::set_t                split_set;
    salru_pkg::tag_t                split_tag;

    salru_pkg::valid_row_t          valid_reg [salru_pkg::SETS];
    salru_pkg::valid_row_t          valid_rd_reg;
    salru_pkg::row_t                ram_rd_data;
    salru_pkg::upd_t                upd;

    logic                           in_beat;
    logic                           out_free;
    logic                           commit;
    logic                           ram_rd_en;

    logic                           out_valid_reg;
    logic                           hit_reg;
    logic [salru_pkg::WAY_OUT_W-1:0] way_reg;
    logic [salru_pkg::SET_OUT_W-1:0] set_out_reg;
    logic [salru_pkg::WORD_W-1:0]   word_out_reg;
    logic [salru_pkg::TAG_W-1:0]    tag_out_reg;
    logic                           ev_valid_reg;
    logic [salru_pkg::TAG_W-1:0]    ev_tag_reg;

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg   <= '0;
            offset_reg <= salru_pkg::OFFSET_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                salru_pkg::REG_MASK:   mask_reg   <= pwdata[salru_pkg::WADDR_W-1:0];
                salru_pkg::REG_OFFSET: offset_reg <= pwdata[salru_pkg::OFFSET_W-1:0];
                default:               mask_reg   <= mask_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            salru_pkg::REG_MASK:   prdata = salru_pkg::PDATA_W'(mask_reg);
            salru_pkg::REG_OFFSET: prdata = salru_pkg::PDATA_W'(offset_reg);
            default:               prdata = '0;
        endcase
    end

    // sequencer
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != salru_pkg::ST_IDLE);
    assign in_beat   = in_valid && !in_stall;
    assign ram_rd_en = (state_reg == salru_pkg::ST_READ);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= salru_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        commit     = 1'b0;
        case (state_reg)
            salru_pkg::ST_IDLE:
            begin
                if (in_beat)
                begin
                    state_next = salru_pkg::ST_SPLIT;
                end
            end
            salru_pkg::ST_SPLIT:
            begin
                state_next = salru_pkg::ST_READ;
            end
            salru_pkg::ST_READ:
            begin
                state_next = salru_pkg::ST_UPDATE;
            end
            salru_pkg::ST_UPDATE:
            begin
                // hold the row until the result register can take it
                if (out_free)
                begin
                    commit     = 1'b1;
                    state_next = salru_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = salru_pkg::ST_IDLE;
            end
        endcase
    end

    // address path
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            addr_reg <= address;
        end
        if (state_reg == salru_pkg::ST_SPLIT)
        begin
            word_reg <= split_word;
            set_reg  <= split_set;
            tag_reg  <= split_tag;
        end
        // valid row is read alongside the ram row
        if (ram_rd_en)
        begin
            valid_rd_reg <= valid_reg[set_reg];
        end
    end

    salru_addr_split u_addr_split
    (
        .address     (addr_reg),
        .mask        (mask_reg),
        .offset_bits (offset_reg),
        .word        (split_word),
        .set_idx     (split_set),
        .tag         (split_tag)
    );

    salru_tag_ram u_tag_ram
    (
        .clk     (clk),
        .rd_en   (ram_rd_en),
        .rd_addr (set_reg),
        .rd_data (ram_rd_data),
        .wr_en   (commit),
        .wr_addr (set_reg),
        .wr_data (upd.row)
    );

    salru_way_update u_way_update
    (
        .row_in   (ram_rd_data),
        .valid_in (valid_rd_reg),
        .tag      (tag_reg),
        .upd      (upd)
    );

    // valid bits in flops so reset empties every set at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < salru_pkg::SETS; s++)
            begin
                valid_reg[s] <= '0;
            end
        end
        else if (commit)
        begin
            valid_reg[set_reg] <= upd.valid;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            hit_reg      <= upd.hit;
            way_reg      <= salru_pkg::WAY_OUT_W'(upd.way);
            set_out_reg  <= salru_pkg::SET_OUT_W'(set_reg);
            word_out_reg <= word_reg;
            tag_out_reg  <= tag_reg;
            ev_valid_reg <= upd.ev_valid;
            ev_tag_reg   <= upd.ev_tag;
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign way_number    = way_reg;
    assign set_number    = set_out_reg;
    assign word_in_block = word_out_reg;
    assign tag_out       = tag_out_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_tag   = ev_tag_reg;

endmodule

### design/salru_addr_split.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salru_addr_split
// Drops the byte bits, squeezes out the interleave bits and splits the
// packed word address into word-in-block, set and tag.
// ----------------------------------------------------------------------------
module salru_addr_split
(
    input  logic [salru_pkg::ADDR_W-1:0]   address,
    input  logic [salru_pkg::WADDR_W-1:0]  mask,
    input  logic [salru_pkg::OFFSET_W-1:0] offset_bits,
    output logic [salru_pkg::WORD_W-1:0]   word,
    output salru_pkg::set_t                set_idx,
    output salru_pkg::tag_t                tag
);

    logic [salru_pkg::WADDR_W-1:0]  waddr;
    logic [salru_pkg::WADDR_W-1:0]  keep;
    logic [salru_pkg::WADDR_W-1:0]  packed_addr;
    logic [salru_pkg::WADDR_W-1:0]  rest;
    logic [salru_pkg::OFFSET_W-1:0] ob;
    logic [salru_pkg::POS_W-1:0]    pos [salru_pkg::WADDR_W];

    assign waddr = address[salru_pkg::ADDR_W-1:2];
    assign keep  = ~mask;

    // target position of each kept bit: count of kept bits below it
    always_comb
    begin
        logic [salru_pkg::WADDR_W-1:0] keep_low;
        for (int b = 0; b < salru_pkg::WADDR_W; b++)
        begin
            keep_low = keep & ((salru_pkg::WADDR_W'(1) << b) - salru_pkg::WADDR_W'(1));
            pos[b]   = salru_pkg::POS_W'($countones(keep_low));
        end
    end

    always_comb
    begin
        packed_addr = '0;
        for (int j = 0; j < salru_pkg::WADDR_W; j++)
        begin
            for (int b = 0; b < salru_pkg::WADDR_W; b++)
            begin
                if (keep[b] && waddr[b] && (pos[b] == salru_pkg::POS_W'(j)))
                begin
                    packed_addr[j] = 1'b1;
                end
            end
        end
    end

    assign ob = (offset_bits > salru_pkg::OFFSET_W'(salru_pkg::MAX_OFFSET))
              ? salru_pkg::OFFSET_W'(salru_pkg::MAX_OFFSET) : offset_bits;

    assign word    = packed_addr[salru_pkg::WORD_W-1:0]
                   & ((salru_pkg::WORD_W'(1) << ob) - salru_pkg::WORD_W'(1));
    assign rest    = packed_addr >> ob;
    assign set_idx = rest[salru_pkg::SET_W-1:0];
    assign tag     = salru_pkg::TAG_W'(rest >> salru_pkg::SET_W);

endmodule

### design/salru_tag_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salru_tag_ram
// One row per set holding the tags and age counters of all ways;
// synchronous write, registered read.
// ----------------------------------------------------------------------------
module salru_tag_ram
(
    input  logic            clk,
    input  logic            rd_en,
    input  salru_pkg::set_t rd_addr,
    output salru_pkg::row_t rd_data,
    input  logic            wr_en,
    input  salru_pkg::set_t wr_addr,
    input  salru_pkg::row_t wr_data
);

    salru_pkg::row_t mem [salru_pkg::SETS];
    salru_pkg::row_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/salru_way_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salru_way_update
// Tag compare across the ways of one set, victim choice and the new row
// contents with updated LRU ages.
// ----------------------------------------------------------------------------
module salru_way_update
(
    input  salru_pkg::row_t       row_in,
    input  salru_pkg::valid_row_t valid_in,
    input  salru_pkg::tag_t       tag,
    output salru_pkg::upd_t       upd
);

    logic            hit;
    logic            inv_found;
    salru_pkg::way_t hit_way;
    salru_pkg::way_t inv_way;
    salru_pkg::way_t old_way;
    salru_pkg::way_t way;
    salru_pkg::age_t ref_age;

    always_comb
    begin
        hit       = 1'b0;
        hit_way   = '0;
        inv_found = 1'b0;
        inv_way   = '0;
        for (int i = salru_pkg::WAYS - 1; i >= 0; i--)
        begin
            if (valid_in[i] && (row_in.tags[i] == tag))
            begin
                hit     = 1'b1;
                hit_way = salru_pkg::WAY_W'(i);
            end
            if (!valid_in[i])
            begin
                inv_found = 1'b1;
                inv_way   = salru_pkg::WAY_W'(i);
            end
        end
    end

    // oldest way, lowest index on ties
    always_comb
    begin
        old_way = '0;
        for (int i = 1; i < salru_pkg::WAYS; i++)
        begin
            if (row_in.ages[i] > row_in.ages[old_way])
            begin
                old_way = salru_pkg::WAY_W'(i);
            end
        end
    end

    assign way     = hit ? hit_way : (inv_found ? inv_way : old_way);
    assign ref_age = row_in.ages[way];

    always_comb
    begin
        upd          = '0;
        upd.hit      = hit;
        upd.way      = way;
        upd.ev_valid = !hit && !inv_found;
        upd.ev_tag   = (!hit && !inv_found) ? row_in.tags[way] : '0;
        upd.row      = row_in;
        upd.valid    = valid_in;
        for (int i = 0; i < salru_pkg::WAYS; i++)
        begin
            if ((salru_pkg::WAY_W'(i) != way) && valid_in[i])
            begin
                // fill into an empty way ages every other valid way
                if ((!hit && inv_found) || (row_in.ages[i] < ref_age))
                begin
                    upd.row.ages[i] = row_in.ages[i] + salru_pkg::AGE_W'(1);
                end
            end
        end
        upd.row.ages[way] = '0;
        if (!hit)
        begin
            upd.row.tags[way] = tag;
        end
        upd.valid[way] = 1'b1;
    end

endmodule

### tb/tb_set_assoc_cache_lru_lookup_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_set_assoc_cache_lru_lookup_core
// Self-checking bench for the set-associative LRU lookup core. A scoreboard
// keeps its own copy of tags, valid bits and age counters and predicts hit,
// way, set, word, tag and eviction for every accepted address beat. The run
// steps through several interleave mask and block size settings written over
// the register port. Both handshakes see random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_set_assoc_cache_lru_lookup_core;

    import salru_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int POOL_SIZE   = 6;

    typedef struct packed {
        logic                 hit;
        logic [WAY_OUT_W-1:0] way;
        logic [SET_OUT_W-1:0] set_idx;
        logic [WORD_W-1:0]    word;
        tag_t                 tag;
        logic                 ev_valid;
        tag_t                 ev_tag;
    } lookup_t;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        bit                drain;
    } access_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [PADDR_W-1:0]     paddr = '0;
    logic [PDATA_W-1:0]     pwdata = '0;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [ADDR_W-1:0]      address = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic                   hit;
    logic [WAY_OUT_W-1:0]   way_number;
    logic [SET_OUT_W-1:0]   set_number;
    logic [WORD_W-1:0]      word_in_block;
    logic [TAG_W-1:0]       tag_out;
    logic                   evicted_valid;
    logic [TAG_W-1:0]       evicted_tag;

    // scoreboard copy of the cache state and registers
    tag_t                   tag_mdl [SETS][WAYS];
    logic                   vld_mdl [SETS][WAYS];
    age_t                   age_mdl [SETS][WAYS];
    logic [WADDR_W-1:0]     mask_mdl;
    logic [OFFSET_W-1:0]    offset_mdl;

    access_t                accesses_todo[$];
    lookup_t                lookups_due[$];
    access_t                next_access;
    lookup_t                due;
    tag_t                   tag_pool [POOL_SIZE];

    int                     errors = 0;
    int                     results_seen = 0;
    int                     cycle_count = 0;
    int                     send_gap = 0;
    int                     recv_hold = 0;
    bit                     send_burst = 1'b0;
    bit                     recv_burst = 1'b0;

    set_assoc_cache_lru_lookup_core u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .address       (address),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hit           (hit),
        .way_number    (way_number),
        .set_number    (set_number),
        .word_in_block (word_in_block),
        .tag_out       (tag_out),
        .evicted_valid (evicted_valid),
        .evicted_tag   (evicted_tag)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch at result %0d, %s: got %h expected %h",
                 results_seen, what, got, want);
        errors++;
    endtask

    // ages of valid ways younger than the touched way move up by one
    function automatic void touch_way(input int s, input int w);
        age_t ref_age;
        ref_age = age_mdl[s][w];
        for (int i = 0; i < WAYS; i++)
            if (i != w && vld_mdl[s][i] && age_mdl[s][i] < ref_age)
                age_mdl[s][i]++;
        age_mdl[s][w] = '0;
    endfunction

    function automatic lookup_t cache_lookup(input logic [ADDR_W-1:0] addr);
        lookup_t            r;
        logic [WADDR_W-1:0] waddr;
        logic [31:0]        packed_addr;
        int                 ob;
        int                 pos;
        int                 s;
        int                 w;
        tag_t               tg;
        r = '0;
        ob = (offset_mdl > MAX_OFFSET) ? MAX_OFFSET : int'(offset_mdl);
        waddr = addr[ADDR_W-1:2];
        packed_addr = '0;
        pos = 0;
        // squeeze out the interleave bits
        for (int b = 0; b < WADDR_W; b++)
            if (!mask_mdl[b])
            begin
                packed_addr[pos] = waddr[b];
                pos++;
            end
        r.word = WORD_W'(packed_addr & ((32'd1 << ob) - 32'd1));
        packed_addr = packed_addr >> ob;
        s = int'(packed_addr & (SETS - 1));
        tg = TAG_W'(packed_addr >> SET_W);
        r.set_idx = SET_OUT_W'(s);
        r.tag = tg;
        w = -1;
        for (int i = 0; i < WAYS; i++)
            if (w < 0 && vld_mdl[s][i] && tag_mdl[s][i] == tg)
                w = i;
        if (w >= 0)
        begin
            r.hit = 1'b1;
            touch_way(s, w);
        end
        else
        begin
            for (int i = 0; i < WAYS; i++)
                if (w < 0 && !vld_mdl[s][i])
                    w = i;
            if (w >= 0)
            begin
                for (int i = 0; i < WAYS; i++)
                    if (i != w && vld_mdl[s][i])
                        age_mdl[s][i]++;
                age_mdl[s][w] = '0;
            end
            else
            begin
                // full set: oldest way goes, lowest index on ties
                w = 0;
                for (int i = 1; i < WAYS; i++)
                    if (age_mdl[s][i] > age_mdl[s][w])
                        w = i;
                r.ev_valid = 1'b1;
                r.ev_tag = tag_mdl[s][w];
                touch_way(s, w);
            end
            tag_mdl[s][w] = tg;
            vld_mdl[s][w] = 1'b1;
        end
        r.way = WAY_OUT_W'(w);
        return r;
    endfunction

    // address for default settings: tag above set above word above byte
    function automatic logic [ADDR_W-1:0] plain_addr(input logic [21:0] tg,
                                                      input logic [5:0] s,
                                                      input logic [1:0] wd,
                                                      input logic [1:0] lo);
        return {tg, s, wd, lo};
    endfunction

    // scatter a packed value back into the unmasked word address bits
    function automatic logic [ADDR_W-1:0] spread_addr(input logic [31:0] p);
        logic [WADDR_W-1:0] waddr;
        int                 pos;
        pos = 0;
        for (int b = 0; b < WADDR_W; b++)
            if (mask_mdl[b])
                waddr[b] = 1'($urandom_range(0, 1));
            else
            begin
                waddr[b] = p[pos];
                pos++;
            end
        return {waddr, 2'($urandom_range(0, 3))};
    endfunction

    task automatic push_addr(input logic [ADDR_W-1:0] addr, input bit drain);
        access_t a;
        a.addr = addr;
        a.drain = drain;
        accesses_todo.push_back(a);
    endtask

    task automatic queue_accesses(input int n);
        int          ob;
        int          sel;
        logic [31:0] p;
        ob = (offset_mdl > MAX_OFFSET) ? MAX_OFFSET : int'(offset_mdl);
        for (int k = 0; k < n; k++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 82)
            begin
                // a few tags over a few sets: hits, fills and evictions
                p = 32'(tag_pool[$urandom_range(0, POOL_SIZE - 1)]) << (ob + SET_W);
                if (sel < 8)
                    p = p | (32'($urandom_range(0, SETS - 1)) << ob);
                else
                    p = p | (32'($urandom_range(0, 3)) << ob);
                p = p | (32'($urandom) & ((32'd1 << ob) - 32'd1));
                push_addr(spread_addr(p), (k == n / 2) || ($urandom_range(0, 63) == 0));
            end
            else
                push_addr($urandom, 1'b0);
        end
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (accesses_todo.size() != 0 || in_valid || lookups_due.size() != 0);
    endtask

    task automatic write_reg(input logic idx, input logic [PDATA_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_MASK)
            mask_mdl = value[WADDR_W-1:0];
        else
            offset_mdl = value[OFFSET_W-1:0];
    endtask

    task automatic run_phase(input logic [WADDR_W-1:0] mask, input logic [OFFSET_W-1:0] ob,
                             input int n);
        wait_idle();
        // junk in the unused upper bits must be dropped
        write_reg(REG_MASK, {2'($urandom), mask});
        write_reg(REG_OFFSET, {28'($urandom), ob});
        for (int k = 0; k < POOL_SIZE; k++)
            tag_pool[k] = TAG_W'($urandom);
        queue_accesses(n);
    endtask

    // address beats
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
                lookups_due.push_back(cache_lookup(address));
            if (!in_valid || !in_stall)
            begin
                if (send_gap != 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (accesses_todo.size() != 0 &&
                         (!accesses_todo[0].drain || lookups_due.size() == 0))
                begin
                    next_access = accesses_todo.pop_front();
                    in_valid <= 1'b1;
                    address <= next_access.addr;
                    if ($urandom_range(0, 31) == 0)
                        send_burst = !send_burst;
                    send_gap = send_burst ? 0 : $urandom_range(0, 11);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result beats
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (lookups_due.size() == 0)
                    note_mismatch("result with nothing due", 32'(out_valid), 32'd0);
                else
                begin
                    due = lookups_due.pop_front();
                    if (hit !== due.hit)
                        note_mismatch("hit", 32'(hit), 32'(due.hit));
                    if (way_number !== due.way)
                        note_mismatch("way_number", 32'(way_number), 32'(due.way));
                    if (set_number !== due.set_idx)
                        note_mismatch("set_number", 32'(set_number), 32'(due.set_idx));
                    if (word_in_block !== due.word)
                        note_mismatch("word_in_block", 32'(word_in_block), 32'(due.word));
                    if (tag_out !== due.tag)
                        note_mismatch("tag_out", 32'(tag_out), 32'(due.tag));
                    if (evicted_valid !== due.ev_valid)
                        note_mismatch("evicted_valid", 32'(evicted_valid),
                                      32'(due.ev_valid));
                    if (evicted_tag !== due.ev_tag)
                        note_mismatch("evicted_tag", 32'(evicted_tag), 32'(due.ev_tag));
                end
                if ($urandom_range(0, 31) == 0)
                    recv_burst = !recv_burst;
                recv_hold = recv_burst ? 0 : $urandom_range(0, 11);
            end
            else if (recv_hold != 0)
                recv_hold--;
            out_stall <= (recv_hold != 0);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("set_assoc_cache_lru_lookup_core regression: fail");
            $finish;
        end
    end

    initial
    begin
        for (int s = 0; s < SETS; s++)
            for (int w = 0; w < WAYS; w++)
            begin
                tag_mdl[s][w] = '0;
                vld_mdl[s][w] = 1'b0;
                age_mdl[s][w] = '0;
            end
        mask_mdl = '0;
        offset_mdl = OFFSET_RESET;

        // directed beats under reset settings: fill set 0, hit young and old
        // ways, then force evictions; plus the all-zero and all-one addresses
        push_addr(plain_addr(22'd0, 6'd0, 2'd0, 2'd0), 1'b0);
        push_addr(32'hFFFF_FFFF, 1'b0);
        push_addr(plain_addr(22'd0, 6'd0, 2'd3, 2'd3), 1'b0);
        push_addr(plain_addr(22'd1, 6'd0, 2'd0, 2'd0), 1'b0);
        push_addr(plain_addr(22'd2, 6'd0, 2'd1, 2'd0), 1'b0);
        push_addr(plain_addr(22'd3, 6'd0, 2'd2, 2'd1), 1'b0);
        push_addr(plain_addr(22'd0, 6'd0, 2'd0, 2'd0), 1'b0);
        push_addr(plain_addr(22'd3, 6'd0, 2'd0, 2'd0), 1'b0);
        push_addr(plain_addr(22'd4, 6'd0, 2'd0, 2'd0), 1'b0);
        push_addr(plain_addr(22'd5, 6'd0, 2'd0, 2'd0), 1'b0);
        push_addr(plain_addr(22'd1, 6'd0, 2'd0, 2'd0), 1'b0);
        push_addr(plain_addr(22'h3FFFFF, 6'd63, 2'd3, 2'd0), 1'b0);
        push_addr(plain_addr(22'h2AAAAA, 6'd21, 2'd1, 2'd2), 1'b0);
        push_addr(plain_addr(22'h155555, 6'd42, 2'd2, 2'd1), 1'b0);
        push_addr(plain_addr(22'h2AAAAA, 6'd21, 2'd0, 2'd0), 1'b0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        run_phase(30'd0, 4'd0, 80);
        run_phase(30'd0, 4'd8, 80);
        // everything masked: all addresses collapse onto one line
        run_phase(30'h3FFF_FFFF, 4'd5, 30);
        // offsets above eight behave as eight
        run_phase(30'($urandom), 4'd15, 80);
        run_phase(30'h3FFF_F000, 4'd3, 80);
        run_phase(30'h0000_0FFF, 4'd1, 80);
        run_phase(30'h2AAA_AAAA, 4'd9, 80);
        run_phase(30'($urandom & $urandom & $urandom), 4'($urandom_range(0, 8)), 80);
        run_phase(30'd0, OFFSET_RESET, 70);

        wait_idle();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("set_assoc_cache_lru_lookup_core regression: pass");
        else
            $display("set_assoc_cache_lru_lookup_core regression: fail");
        $finish;
    end

endmodule
